### design/dgfs_pkg.sv
// ----------------------------------------------------------------------------
// dgfs_pkg
// Shared widths and divider request/response types for the disk geometry
// inference block.
// ----------------------------------------------------------------------------
package dgfs_pkg;

  // dividend is a sector count, divisor a small candidate factor
  localparam int DividendW = 23;
  localparam int DivisorW  = 9;

  // reset values of the track count bounds
  localparam logic [15:0] MinTracksReset = 16'd100;
  localparam logic [15:0] MaxTracksReset = 16'd9999;

  // register indexes of the configuration port
  localparam logic RegMinTracks = 1'b0;
  localparam logic RegMaxTracks = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DividendW-1:0] quotient;
    logic [DivisorW-1:0]  remainder;
  } div_rsp_t;

endpackage

### design/dgfs_div.sv
// ----------------------------------------------------------------------------
// dgfs_div
// Restoring divider, one quotient bit per cycle; done pulses once when the
// quotient and remainder are ready.
// ----------------------------------------------------------------------------
module dgfs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dgfs_pkg::div_req_t req,
  output dgfs_pkg::div_rsp_t rsp
);

  localparam int DW   = dgfs_pkg::DividendW;
  localparam int SW   = dgfs_pkg::DivisorW;
  localparam int CntW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CntW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dsr_r;

  logic [SW:0]   cand;
  logic [SW:0]   diff;
  logic          ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    cand = {rem_r, quo_r[DW-1]};
    diff = cand - {1'b0, dsr_r};
    ge   = (cand >= {1'b0, dsr_r});
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[DW-2:0], ge};
        rem_r <= ge ? diff[SW-1:0] : cand[SW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

### design/disk_geometry_from_size.sv
// Result path: an image that no sector size divides goes straight from the
// input transfer to the FIN state and the output register; any other image
// first runs up to 44 trial divisions in turn on the divider.
// Throughput: one image at a time; the shared bit-serial divider sets the pace.
// A finished result waits in the output register while the next image is taken.
// Reset (rst_n, synchronous, active low) clears control state and sets the
// track count bounds to 100 and 9999.
// ----------------------------------------------------------------------------
// disk_geometry_from_size
// Infers sector size, sides, tracks and sectors per track from an image size
// with a sequencer driving one shared divider.
// ----------------------------------------------------------------------------
module disk_geometry_from_size (
  input  logic        clk,
  input  logic        rst_n,
  // input stream: [30:0] image_bytes, [31] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // result stream: [0] found, [23:1] total_sectors, [27:24] side_count,
  // [49:28] track_count, [66:50] sectors_per_track, [77:67] sector_bytes,
  // [79:78] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  // configuration writes
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DW = dgfs_pkg::DividendW;
  localparam int SW = dgfs_pkg::DivisorW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIM,
    ST_SIDE,
    ST_SPT,
    ST_HUND,
    ST_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [15:0]   min_trk_r, max_trk_r;
  logic          found_r, found_nxt;
  logic [DW-1:0] total_r, total_nxt;
  logic [DW-1:0] rest_r, rest_nxt;
  logic [10:0]   secb_r, secb_nxt;
  logic [5:0]    pref_r, pref_nxt;
  logic [3:0]    sd_r, sd_nxt;
  logic [5:0]    cand_r, cand_nxt;
  logic [3:0]    sides_r, sides_nxt;
  logic [21:0]   tracks_r, tracks_nxt;
  logic [16:0]   spt_r, spt_nxt;
  logic          start_r, start_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [SW-1:0] dsr_r, dsr_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [79:0]   out_tdata_r, out_tdata_nxt;

  dgfs_pkg::div_req_t div_req;
  dgfs_pkg::div_rsp_t div_rsp;

  logic [30:0]   bytes;
  logic          rem_zero;
  logic [SW-1:0] unit_next;
  logic          in_range;
  logic          in_xfer;

  assign div_req.start    = start_r;
  assign div_req.dividend = dvd_r;
  assign div_req.divisor  = dsr_r;

  dgfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign bytes     = in_tdata[30:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign rem_zero  = (div_rsp.remainder == '0);
  assign in_range  = (div_rsp.quotient >= {7'd0, min_trk_r}) &&
                     (div_rsp.quotient <= {7'd0, max_trk_r});
  // sides times preferred sectors per track for the next lower side count
  assign unit_next = SW'({5'd0, sd_r - 4'd1} * {3'd0, pref_r});

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    found_nxt      = found_r;
    total_nxt      = total_r;
    rest_nxt       = rest_r;
    secb_nxt       = secb_r;
    pref_nxt       = pref_r;
    sd_nxt         = sd_r;
    cand_nxt       = cand_r;
    sides_nxt      = sides_r;
    tracks_nxt     = tracks_r;
    spt_nxt        = spt_r;
    start_nxt      = 1'b0;
    dvd_nxt        = dvd_r;
    dsr_nxt        = dsr_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          sides_nxt  = '0;
          tracks_nxt = '0;
          spt_nxt    = '0;
          sd_nxt     = 4'd8;
          found_nxt  = 1'b1;
          // first sector size that divides: 512, then 256, then 1024
          if (bytes[8:0] == '0) begin
            secb_nxt  = 11'd512;
            pref_nxt  = 6'd17;
            total_nxt = DW'(bytes >> 9);
            dsr_nxt   = SW'(8 * 17);
            state_nxt = ST_PRIM;
          end else if (bytes[7:0] == '0) begin
            secb_nxt  = 11'd256;
            pref_nxt  = 6'd33;
            total_nxt = DW'(bytes >> 8);
            dsr_nxt   = SW'(8 * 33);
            state_nxt = ST_PRIM;
          end else if (bytes[9:0] == '0) begin
            secb_nxt  = 11'd1024;
            pref_nxt  = 6'd9;
            total_nxt = DW'(bytes >> 10);
            dsr_nxt   = SW'(8 * 9);
            state_nxt = ST_PRIM;
          end else begin
            found_nxt = 1'b0;
            secb_nxt  = '0;
            total_nxt = '0;
            state_nxt = ST_FIN;
          end
          dvd_nxt   = total_nxt;
          start_nxt = (state_nxt == ST_PRIM);
        end
      end

      // primary search, sides 8 down to 2 with preferred sectors per track
      ST_PRIM: begin
        if (div_rsp.done) begin
          if (rem_zero && in_range) begin
            sides_nxt  = sd_r;
            tracks_nxt = div_rsp.quotient[21:0];
            spt_nxt    = {11'd0, pref_r};
            state_nxt  = ST_FIN;
          end else if (sd_r == 4'd2) begin
            sd_nxt    = 4'd8;
            dvd_nxt   = total_r;
            dsr_nxt   = SW'(8);
            start_nxt = 1'b1;
            state_nxt = ST_SIDE;
          end else begin
            sd_nxt    = sd_r - 4'd1;
            dvd_nxt   = total_r;
            dsr_nxt   = unit_next;
            start_nxt = 1'b1;
          end
        end
      end

      // fallback side count: first of 8, 6, 4, 2 that divides
      ST_SIDE: begin
        if (div_rsp.done) begin
          if (rem_zero || sd_r == 4'd2) begin
            if (rem_zero) begin
              sides_nxt = sd_r;
              rest_nxt  = div_rsp.quotient;
            end else begin
              sides_nxt = '0;
              rest_nxt  = total_r;
            end
            cand_nxt  = 6'd33;
            dvd_nxt   = rest_nxt;
            dsr_nxt   = SW'(33);
            start_nxt = 1'b1;
            state_nxt = ST_SPT;
          end else begin
            sd_nxt    = sd_r - 4'd2;
            dvd_nxt   = total_r;
            dsr_nxt   = {5'd0, sd_r - 4'd2};
            start_nxt = 1'b1;
          end
        end
      end

      // fallback sectors per track: first divisor 33 down to 2
      ST_SPT: begin
        if (div_rsp.done) begin
          if (rem_zero) begin
            tracks_nxt = div_rsp.quotient[21:0];
            spt_nxt    = {11'd0, cand_r};
            state_nxt  = ST_FIN;
          end else if (cand_r == 6'd2) begin
            dvd_nxt   = rest_r;
            dsr_nxt   = SW'(100);
            start_nxt = 1'b1;
            state_nxt = ST_HUND;
          end else begin
            cand_nxt  = cand_r - 6'd1;
            dvd_nxt   = rest_r;
            dsr_nxt   = {3'd0, cand_r - 6'd1};
            start_nxt = 1'b1;
          end
        end
      end

      // last resort: 100 tracks, else sides, tracks and sectors per track zero
      ST_HUND: begin
        if (div_rsp.done) begin
          if (rem_zero) begin
            tracks_nxt = 22'd100;
            spt_nxt    = div_rsp.quotient[16:0];
          end else begin
            sides_nxt  = '0;
            tracks_nxt = '0;
            spt_nxt    = '0;
          end
          state_nxt = ST_FIN;
        end
      end

      // hand over to the output register once it is free
      ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, secb_r, spt_r, tracks_r, sides_r, total_r, found_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      min_trk_r    <= dgfs_pkg::MinTracksReset;
      max_trk_r    <= dgfs_pkg::MaxTracksReset;
    end else begin
      state_r      <= state_nxt;
      start_r      <= start_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wen && cfg_index == dgfs_pkg::RegMinTracks) begin
        min_trk_r <= cfg_data;
      end
      if (cfg_wen && cfg_index == dgfs_pkg::RegMaxTracks) begin
        max_trk_r <= cfg_data;
      end
    end
    found_r     <= found_nxt;
    total_r     <= total_nxt;
    rest_r      <= rest_nxt;
    secb_r      <= secb_nxt;
    pref_r      <= pref_nxt;
    sd_r        <= sd_nxt;
    cand_r      <= cand_nxt;
    sides_r     <= sides_nxt;
    tracks_r    <= tracks_nxt;
    spt_r       <= spt_nxt;
    dvd_r       <= dvd_nxt;
    dsr_r       <= dsr_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // a division is never started while one is in progress
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // an image with no dividing sector size reports an all-zero geometry
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[77:1] == '0))
    else $error("non-zero geometry without a sector size");

  // side count never exceeds eight
  a_sides_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:24] <= 4'd8))
    else $error("side count out of range");

  // divider only runs while the sequencer is in a search state
  a_div_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r != ST_IDLE && state_r != ST_FIN))
    else $error("divider busy outside a search");

endmodule

### sim/tb_disk_geometry_from_size.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_geometry_from_size
// Streams image sizes into the geometry inference block and checks every
// result against a behavioral geometry search in the bench. It covers
// directed corner sizes, several track count bounds settings and mixed random
// traffic, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_disk_geometry_from_size;

  // preferred sectors per track for each sector size
  localparam int unsigned Spt512  = 17;
  localparam int unsigned Spt256  = 33;
  localparam int unsigned Spt1024 = 9;

  // msb first, so a cast of out_tdata[77:0] lines up with the port fields
  typedef struct packed {
    logic [10:0] sector_bytes;
    logic [16:0] sectors_per_track;
    logic [21:0] track_count;
    logic [3:0]  side_count;
    logic [22:0] total_sectors;
    logic        found;
  } geometry_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        cfg_wen;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // bench copy of the track count bounds
  logic [15:0] bound_lo;
  logic [15:0] bound_hi;

  geometry_t   pending_geometry[$];
  int unsigned mismatch_count;
  bit          in_gaps_on;

  disk_geometry_from_size DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on run time
  initial begin : watchdog
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  // expected geometry for one image size under the current bounds
  function automatic geometry_t infer_geometry(input logic [30:0] image_bytes);
    geometry_t   g;
    int unsigned bytes, total, unit, q, rest, secb, pref;
    bit          done;
    g = '0;
    bytes = 32'(image_bytes);
    // a multiple of 1024 is always a multiple of 512, so 512 wins first
    if (bytes % 512 == 0) begin
      secb = 512;
      pref = Spt512;
    end else if (bytes % 256 == 0) begin
      secb = 256;
      pref = Spt256;
    end else if (bytes % 1024 == 0) begin
      secb = 1024;
      pref = Spt1024;
    end else begin
      return g;
    end
    g.found = 1'b1;
    g.sector_bytes = 11'(secb);
    total = bytes / secb;
    g.total_sectors = 23'(total);

    // primary search with preferred sectors per track
    done = 1'b0;
    for (int sd = 8; sd >= 2 && !done; sd--) begin
      unit = sd * pref;
      if (total % unit == 0) begin
        q = total / unit;
        if (q >= bound_lo && q <= bound_hi) begin
          g.side_count = 4'(sd);
          g.track_count = 22'(q);
          g.sectors_per_track = 17'(pref);
          done = 1'b1;
        end
      end
    end
    if (done) return g;

    // fallback on divisibility
    rest = total;
    for (int sd = 8; sd >= 2; sd -= 2) begin
      if (total % sd == 0) begin
        g.side_count = 4'(sd);
        rest = total / sd;
        break;
      end
    end
    for (int s = 33; s >= 2; s--) begin
      if (rest % s == 0) begin
        g.track_count = 22'(rest / s);
        g.sectors_per_track = 17'(s);
        return g;
      end
    end
    if (rest % 100 == 0) begin
      g.track_count = 22'd100;
      g.sectors_per_track = 17'(rest / 100);
      return g;
    end
    g.side_count = '0;
    return g;
  endfunction

  // gap length: mostly none or short, sometimes long
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // image built from a geometry, shrunk until it fits 31 bits
  function automatic logic [30:0] geometry_image();
    longint unsigned secb, sides, spt, tracks, bytes;
    case ($urandom_range(0, 2))
      0: begin secb = 512;  spt = Spt512;  end
      1: begin secb = 256;  spt = Spt256;  end
      default: begin secb = 1024; spt = Spt1024; end
    endcase
    if ($urandom_range(0, 9) < 3) spt = $urandom_range(1, 40);
    sides = $urandom_range(1, 8);
    case ($urandom_range(0, 4))
      0, 1: tracks = $urandom_range(bound_lo, bound_hi);
      2: begin
        case ($urandom_range(0, 3))
          0: tracks = longint'(bound_lo) - 1;
          1: tracks = bound_lo;
          2: tracks = bound_hi;
          default: tracks = longint'(bound_hi) + 1;
        endcase
      end
      default: tracks = $urandom_range(1, 200);
    endcase
    bytes = secb * sides * spt * tracks;
    while (bytes > 64'h7fff_ffff) begin
      tracks = tracks >> 1;
      bytes = secb * sides * spt * tracks;
    end
    return bytes[30:0];
  endfunction

  // mix of well-formed geometries and noise
  function automatic logic [30:0] random_image();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return geometry_image();
    if (r < 65) return 31'($urandom()) & 31'h7fff_ff00;
    if (r < 80) return 31'($urandom());
    if (r < 90) return 31'($urandom_range(0, 70000));
    // odd sector count, often without small factors
    return {22'($urandom_range(0, 4194303)), 9'd0} | 31'h200;
  endfunction

  // one input transfer, expectation recorded at acceptance
  task automatic send_image(input logic [30:0] bytes);
    int unsigned gap;
    gap = in_gaps_on ? idle_cycles() : 0;
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, bytes};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_geometry.push_back(infer_geometry(bytes));
  endtask

  // stop sending and wait for every result
  task automatic drain_results();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_geometry.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write both bounds while idle
  task automatic set_bounds(input logic [15:0] lo, input logic [15:0] hi);
    drain_results();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= dgfs_pkg::RegMinTracks;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= dgfs_pkg::RegMaxTracks;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    bound_lo = lo;
    bound_hi = hi;
  endtask

  // corner sizes under the reset bounds
  task automatic test_directed_sizes();
    logic [30:0] sizes[$];
    sizes = '{
      31'd0, 31'h7fff_ffff, 31'd1, 31'd255, 31'd257, 31'd256, 31'd512, 31'd1024,
      31'h7fff_ff00, 31'h7fff_fe00,
      31'(80 * 2 * 17 * 512),      // tracks below the minimum
      31'(100 * 2 * 17 * 512),     // primary hit on two sides
      31'(9999 * 8 * 17 * 512),    // primary hit at the maximum
      31'(10000 * 8 * 17 * 512),   // above the maximum
      31'(101 * 3 * 33 * 256),     // 256-byte sectors, odd sides
      31'(37 * 512),               // nothing divides, zero geometry
      31'(100 * 2 * 9 * 1024),     // 1024-byte geometry taken as 512
      31'(35 * 512)                // odd count, no sides
    };
    in_gaps_on = 1'b1;
    foreach (sizes[i]) send_image(sizes[i]);
  endtask

  // several bounds settings, extremes first
  task automatic test_bound_settings();
    logic [15:0] lo_list[$];
    logic [15:0] hi_list[$];
    lo_list = '{16'd0, 16'd65535, 16'd1, 16'd500, 16'd40, 16'd0};
    hi_list = '{16'd65535, 16'd65535, 16'd1, 16'd10, 16'd80, 16'd0};
    lo_list[5] = 16'($urandom_range(1, 65535));
    hi_list[5] = 16'($urandom_range(1, 65535));
    foreach (lo_list[p]) begin
      set_bounds(lo_list[p], hi_list[p]);
      in_gaps_on = (p % 2 == 0);
      send_image(31'd0);
      repeat (69) send_image(random_image());
    end
  endtask

  // random bounds with mostly realistic track counts
  task automatic test_random_traffic();
    logic [15:0] lo;
    in_gaps_on = 1'b1;
    repeat (2) begin
      lo = 16'($urandom_range(1, 300));
      set_bounds(lo, 16'($urandom_range(lo, 65535)));
      repeat (50) send_image(random_image());
    end
  endtask

  // output ready: runs of ready with random stalls between
  initial begin : ready_driver
    int unsigned run, stall;
    out_tready = 1'b0;
    forever begin
      run = $urandom_range(1, 40);
      stall = idle_cycles();
      @(negedge clk) out_tready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      if (stall > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    geometry_t got;
    geometry_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = geometry_t'(out_tdata[77:0]);
      if (pending_geometry.size() == 0) begin
        $error("result transfer with no image pending: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_geometry.pop_front();
        check_field("found", want.found, got.found);
        check_field("total_sectors", want.total_sectors, got.total_sectors);
        check_field("side_count", want.side_count, got.side_count);
        check_field("track_count", want.track_count, got.track_count);
        check_field("sectors_per_track", want.sectors_per_track, got.sectors_per_track);
        check_field("sector_bytes", want.sector_bytes, got.sector_bytes);
      end
    end
  end

  // reset, then the tests in turn
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_wen        = 1'b0;
    cfg_index      = dgfs_pkg::RegMinTracks;
    cfg_data       = '0;
    bound_lo       = dgfs_pkg::MinTracksReset;
    bound_hi       = dgfs_pkg::MaxTracksReset;
    mismatch_count = 0;
    in_gaps_on     = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_sizes();
    test_bound_settings();
    test_random_traffic();
    drain_results();
    repeat (50) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### disk_geometry_from_size.f
design/dgfs_pkg.sv
design/dgfs_div.sv
design/disk_geometry_from_size.sv
sim/tb_disk_geometry_from_size.sv
